/* hdl/hss_pkg.sv */
package hss_pkg;

  localparam int unsigned HalfW  = 64;
  localparam int unsigned DistW  = 8;
  localparam int unsigned CountW = 32;
  localparam int unsigned DataW  = 64;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned RegIdxW = 2;

  localparam logic [RegIdxW-1:0] REG_QUERY_LOW      = 2'd0;
  localparam logic [RegIdxW-1:0] REG_QUERY_HIGH     = 2'd1;
  localparam logic [RegIdxW-1:0] REG_DISTANCE_LIMIT = 2'd2;
  localparam logic [RegIdxW-1:0] REG_RESULT_LIMIT   = 2'd3;

  localparam logic [CountW-1:0] IndexMax = {CountW{1'b1}};

  typedef struct packed {
    logic [HalfW-1:0]  query_low;
    logic [HalfW-1:0]  query_high;
    logic [DistW-1:0]  distance_limit;
    logic [CountW-1:0] result_limit;
  } cfg_t;

endpackage

/* hdl/hss_regs.sv */
module hss_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [hss_pkg::AddrW-1:0] paddr,
  input  logic [hss_pkg::DataW-1:0] pwdata,
  output logic [hss_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output hss_pkg::cfg_t             cfg_o
);
  import hss_pkg::*;

  cfg_t               cfg_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;

  assign reg_idx = paddr[AddrW-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.query_low      <= '0;
      cfg_q.query_high     <= '0;
      cfg_q.distance_limit <= '0;
      cfg_q.result_limit   <= {CountW{1'b1}};
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_QUERY_LOW:      cfg_q.query_low      <= pwdata;
        REG_QUERY_HIGH:     cfg_q.query_high     <= pwdata;
        REG_DISTANCE_LIMIT: cfg_q.distance_limit <= pwdata[DistW-1:0];
        REG_RESULT_LIMIT:   cfg_q.result_limit   <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_QUERY_LOW:      prdata = cfg_q.query_low;
      REG_QUERY_HIGH:     prdata = cfg_q.query_high;
      REG_DISTANCE_LIMIT: prdata = {{(DataW-DistW){1'b0}}, cfg_q.distance_limit};
      REG_RESULT_LIMIT:   prdata = {{(DataW-CountW){1'b0}}, cfg_q.result_limit};
      default:            prdata = '0;
    endcase
  end

endmodule

/* hdl/hss_distance.sv */
module hss_distance (
  input  logic [hss_pkg::HalfW-1:0] code_low_i,
  input  logic [hss_pkg::HalfW-1:0] code_high_i,
  input  logic [hss_pkg::HalfW-1:0] query_low_i,
  input  logic [hss_pkg::HalfW-1:0] query_high_i,
  output logic [hss_pkg::DistW-1:0] distance_o
);
  import hss_pkg::*;

  logic [2*HalfW-1:0] diff;
  logic [1:0] s1 [64];
  logic [2:0] s2 [32];
  logic [3:0] s3 [16];
  logic [4:0] s4 [8];
  logic [5:0] s5 [4];
  logic [6:0] s6 [2];

  assign diff = {code_high_i ^ query_high_i, code_low_i ^ query_low_i};

  // adder tree, one level per loop
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      s1[i] = {1'b0, diff[2*i]} + {1'b0, diff[2*i+1]};
    end
    for (int i = 0; i < 32; i++) begin
      s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s6[i] = {1'b0, s5[2*i]} + {1'b0, s5[2*i+1]};
    end
    distance_o = {1'b0, s6[0]} + {1'b0, s6[1]};
  end

endmodule

/* hdl/hamming_similarity_scan_top.sv */
// Pipeline: input register, popcount and compare, result register.
// One word per cycle while out_ready_i does not stall the result register.
// The input side keeps accepting while a result waits, until both registers are full.
// Reset (rst_ni low, asynchronous): pipeline empty, record index and match count zero,
// query and distance limit zero, result limit all ones.
module hamming_similarity_scan_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hss_pkg::AddrW-1:0]  paddr,
  input  logic [hss_pkg::DataW-1:0]  pwdata,
  output logic [hss_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [hss_pkg::HalfW-1:0]  code_low_i,
  input  logic [hss_pkg::HalfW-1:0]  code_high_i,
  input  logic                       last_record_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       is_match_o,
  output logic [hss_pkg::CountW-1:0] record_index_o,
  output logic [hss_pkg::DistW-1:0]  distance_o,
  output logic [hss_pkg::CountW-1:0] match_count_o,
  output logic                       scan_done_o
);
  import hss_pkg::*;

  cfg_t cfg;

  logic              in_valid_q;
  logic [HalfW-1:0]  code_low_q;
  logic [HalfW-1:0]  code_high_q;
  logic              last_q;

  logic              out_valid_q;
  logic              match_q;
  logic [CountW-1:0] index_q;
  logic [DistW-1:0]  dist_q;
  logic [CountW-1:0] count_q;
  logic              done_q;

  logic [CountW-1:0] next_index_q, next_index_d;
  logic [CountW-1:0] found_count_q, found_count_d;

  logic [DistW-1:0]  hdist;
  logic              match;
  logic [CountW-1:0] count_inc;
  logic              advance;
  logic              fire;

  hss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hss_distance u_distance (
    .code_low_i   (code_low_q),
    .code_high_i  (code_high_q),
    .query_low_i  (cfg.query_low),
    .query_high_i (cfg.query_high),
    .distance_o   (hdist)
  );

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign fire       = in_valid_q && advance;

  assign match     = (hdist <= cfg.distance_limit) && (found_count_q < cfg.result_limit);
  assign count_inc = match ? found_count_q + 1'b1 : found_count_q;

  always_comb begin
    next_index_d  = next_index_q;
    found_count_d = found_count_q;
    if (fire) begin
      if (last_q) begin
        next_index_d  = '0;
        found_count_d = '0;
      end else begin
        found_count_d = count_inc;
        if (next_index_q != IndexMax) begin
          next_index_d = next_index_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      next_index_q  <= '0;
      found_count_q <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      next_index_q  <= next_index_d;
      found_count_q <= found_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      code_low_q  <= code_low_i;
      code_high_q <= code_high_i;
      last_q      <= last_record_i;
    end
    if (fire) begin
      match_q <= match;
      index_q <= next_index_q;
      dist_q  <= hdist;
      count_q <= count_inc;
      done_q  <= last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_match_o     = match_q;
  assign record_index_o = index_q;
  assign distance_o     = dist_q;
  assign match_count_o  = count_q;
  assign scan_done_o    = done_q;

endmodule

/* hdl/hss_checker.sv */
module hss_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       is_match_o,
  input logic [hss_pkg::CountW-1:0] record_index_o,
  input logic [hss_pkg::DistW-1:0]  distance_o,
  input logic [hss_pkg::CountW-1:0] match_count_o,
  input logic                       scan_done_o
);
  import hss_pkg::*;

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(is_match_o) && $stable(record_index_o)
      && $stable(distance_o) && $stable(match_count_o) && $stable(scan_done_o))
    else $error("result word changed while stalled");

  a_match_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_match_o |-> match_count_o != '0)
    else $error("match reported with zero count");

endmodule

bind hamming_similarity_scan_top hss_checker u_hss_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [hss_pkg::HalfW-1:0] code_low;
    logic [hss_pkg::HalfW-1:0] code_high;
    logic                      last_record;
  } record_t;

  typedef struct packed {
    logic                       is_match;
    logic [hss_pkg::CountW-1:0] record_index;
    logic [hss_pkg::DistW-1:0]  distance;
    logic [hss_pkg::CountW-1:0] match_count;
    logic                       scan_done;
  } scan_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [hss_pkg::AddrW-1:0]  paddr = '0;
  logic [hss_pkg::DataW-1:0]  pwdata = '0;
  logic [hss_pkg::DataW-1:0]  prdata;
  logic                       pready;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [hss_pkg::HalfW-1:0]  code_low_i = '0;
  logic [hss_pkg::HalfW-1:0]  code_high_i = '0;
  logic                       last_record_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic                       is_match_o;
  logic [hss_pkg::CountW-1:0] record_index_o;
  logic [hss_pkg::DistW-1:0]  distance_o;
  logic [hss_pkg::CountW-1:0] match_count_o;
  logic                       scan_done_o;

  hamming_similarity_scan_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .code_low_i    (code_low_i),
    .code_high_i   (code_high_i),
    .last_record_i (last_record_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_match_o    (is_match_o),
    .record_index_o(record_index_o),
    .distance_o    (distance_o),
    .match_count_o (match_count_o),
    .scan_done_o   (scan_done_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // scan model
  hss_pkg::cfg_t              cfg_model;
  logic [hss_pkg::CountW-1:0] scan_pos = '0;
  logic [hss_pkg::CountW-1:0] scan_hits = '0;

  record_t      pending_records[$];
  scan_result_t due_results[$];
  int           issued_n = 0;
  int           checked_n = 0;
  int           err_n = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;

  function automatic scan_result_t score_record(input record_t r);
    scan_result_t res;
    int unsigned  hdist;
    hdist = $countones(r.code_low ^ cfg_model.query_low)
          + $countones(r.code_high ^ cfg_model.query_high);
    res.is_match = (hdist <= cfg_model.distance_limit) && (scan_hits < cfg_model.result_limit);
    if (res.is_match) scan_hits++;
    res.record_index = scan_pos;
    res.distance     = hdist[hss_pkg::DistW-1:0];
    res.match_count  = scan_hits;
    res.scan_done    = r.last_record;
    if (scan_pos != hss_pkg::IndexMax) scan_pos++;
    if (r.last_record) begin
      scan_pos  = '0;
      scan_hits = '0;
    end
    return res;
  endfunction

  // record at Hamming distance k from the current query
  function automatic record_t near_record(input int k, input bit last);
    logic [127:0] flips;
    record_t      r;
    int           n;
    int           p;
    flips = '0;
    n = 0;
    while (n < k) begin
      p = $urandom_range(0, 127);
      if (!flips[p]) begin
        flips[p] = 1'b1;
        n++;
      end
    end
    r.code_low    = cfg_model.query_low ^ flips[63:0];
    r.code_high   = cfg_model.query_high ^ flips[127:64];
    r.last_record = last;
    return r;
  endfunction

  function automatic record_t random_record(input bit last);
    record_t r;
    r.code_low    = {$urandom, $urandom};
    r.code_high   = {$urandom, $urandom};
    r.last_record = last;
    return r;
  endfunction

  task automatic issue(input record_t r);
    pending_records.push_back(r);
    issued_n++;
  endtask

  task automatic drain();
    while (checked_n < issued_n) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [hss_pkg::RegIdxW-1:0] idx,
                           input logic [hss_pkg::DataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= hss_pkg::AddrW'(idx) << 3;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      hss_pkg::REG_QUERY_LOW:      cfg_model.query_low = val;
      hss_pkg::REG_QUERY_HIGH:     cfg_model.query_high = val;
      hss_pkg::REG_DISTANCE_LIMIT: cfg_model.distance_limit = val[hss_pkg::DistW-1:0];
      hss_pkg::REG_RESULT_LIMIT:   cfg_model.result_limit = val[hss_pkg::CountW-1:0];
      default: ;
    endcase
  endtask

  // record driver
  int      tx_gap = 0;
  record_t tx_rec;
  record_t acc_rec;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        acc_rec.code_low    = code_low_i;
        acc_rec.code_high   = code_high_i;
        acc_rec.last_record = last_record_i;
        due_results.push_back(score_record(acc_rec));
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_records.size() != 0) begin
          tx_rec = pending_records.pop_front();
          code_low_i    <= tx_rec.code_low;
          code_high_i   <= tx_rec.code_high;
          last_record_i <= tx_rec.last_record;
          in_valid_i    <= 1'b1;
          if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
            tx_gap = $urandom_range(1, 7);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  int           rx_gap = 0;
  int           rx_hold = 0;
  scan_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result word: index %0d", record_index_o);
          err_n++;
        end else begin
          want = due_results.pop_front();
          if (is_match_o !== want.is_match) begin
            $error("is_match: expected %0d, got %0d", want.is_match, is_match_o);
            err_n++;
          end
          if (record_index_o !== want.record_index) begin
            $error("record_index: expected %0d, got %0d", want.record_index, record_index_o);
            err_n++;
          end
          if (distance_o !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, distance_o);
            err_n++;
          end
          if (match_count_o !== want.match_count) begin
            $error("match_count: expected %0d, got %0d", want.match_count, match_count_o);
            err_n++;
          end
          if (scan_done_o !== want.scan_done) begin
            $error("scan_done: expected %0d, got %0d", want.scan_done, scan_done_o);
            err_n++;
          end
          checked_n++;
          if (checked_n == 400 || checked_n == 1100) rx_hold = 60;
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct)
          rx_gap = $urandom_range(1, 7);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int                        k;
    int                        scan_len;
    bit                        last;
    logic [hss_pkg::DataW-1:0] val;
    cfg_model.query_low      = '0;
    cfg_model.query_high     = '0;
    cfg_model.distance_limit = '0;
    cfg_model.result_limit   = hss_pkg::IndexMax;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: only an exact hit matches
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    issue('{64'h0, 64'h0, 1'b0});
    issue('{'1, '1, 1'b0});
    issue('{64'h1, 64'h0, 1'b0});
    issue('{64'h0, 64'h8000_0000_0000_0000, 1'b0});
    issue('{64'h0, 64'h0, 1'b1});
    drain();

    // widest distance limit, result limit hit after three
    write_reg(hss_pkg::REG_QUERY_LOW, '1);
    write_reg(hss_pkg::REG_QUERY_HIGH, 64'h0123_4567_89ab_cdef);
    write_reg(hss_pkg::REG_DISTANCE_LIMIT, 64'd128);
    write_reg(hss_pkg::REG_RESULT_LIMIT, 64'd3);
    issue(near_record(0, 1'b0));
    issue(near_record(128, 1'b0));
    issue(random_record(1'b0));
    issue(random_record(1'b0));
    issue(random_record(1'b0));
    issue(random_record(1'b1));
    drain();

    // limit above 128 with junk in upper bits, result limit zero
    write_reg(hss_pkg::REG_DISTANCE_LIMIT, 64'hdead_beef_0000_00ff);
    write_reg(hss_pkg::REG_RESULT_LIMIT, 64'h0);
    issue(near_record(0, 1'b0));
    issue(near_record(128, 1'b0));
    issue(random_record(1'b1));
    drain();

    // settings changed in the middle of a scan
    write_reg(hss_pkg::REG_DISTANCE_LIMIT, 64'd4);
    write_reg(hss_pkg::REG_RESULT_LIMIT, {32'hffff_ffff, 32'hffff_ffff});
    for (int i = 0; i < 4; i++) issue(near_record(i + 1, 1'b0));
    drain();
    write_reg(hss_pkg::REG_RESULT_LIMIT, 64'd2);
    write_reg(hss_pkg::REG_DISTANCE_LIMIT, 64'd1);
    issue(near_record(0, 1'b0));
    issue(near_record(1, 1'b0));
    issue(near_record(0, 1'b1));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(hss_pkg::REG_QUERY_LOW, {$urandom, $urandom});
      write_reg(hss_pkg::REG_QUERY_HIGH, {$urandom, $urandom});
      val = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : '0;
      case ($urandom_range(0, 5))
        0:       val[7:0] = 8'd0;
        1:       val[7:0] = 8'd128;
        2:       val[7:0] = 8'($urandom_range(129, 255));
        3:       val[7:0] = 8'($urandom_range(1, 8));
        default: val[7:0] = 8'($urandom_range(0, 128));
      endcase
      write_reg(hss_pkg::REG_DISTANCE_LIMIT, val);
      val = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : '0;
      case ($urandom_range(0, 5))
        0:       val[31:0] = 32'd0;
        1:       val[31:0] = 32'd1;
        2:       val[31:0] = $urandom_range(2, 12);
        3:       val[31:0] = $urandom;
        default: val[31:0] = hss_pkg::IndexMax;
      endcase
      write_reg(hss_pkg::REG_RESULT_LIMIT, val);

      if (ph == 7) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = (ph % 3 == 1) ? 0 : $urandom_range(10, 40);
        rx_idle_pct = (ph % 3 == 2) ? 0 : $urandom_range(10, 40);
      end
      case ($urandom_range(0, 2))
        0:       scan_len = 3;
        1:       scan_len = 20;
        default: scan_len = 60;
      endcase

      for (int n = 0; n < 200; n++) begin
        last = ($urandom_range(0, scan_len) == 0);
        if ($urandom_range(0, 3) == 0) begin
          issue(random_record(last));
        end else begin
          if ($urandom_range(0, 2) == 0) begin
            k = $urandom_range(0, 128);
          end else begin
            k = int'(cfg_model.distance_limit) + int'($urandom_range(0, 6)) - 3;
            if (k < 0) k = 0;
            if (k > 128) k = 128;
          end
          issue(near_record(k, last));
        end
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (err_n == 0 && due_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/hss_pkg.sv
hdl/hss_regs.sv
hdl/hss_distance.sv
hdl/hamming_similarity_scan_top.sv
hdl/hss_checker.sv
tb/testbench.sv
